// File: rtl/owrs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owrs_pkg
// Types, codes and CRC-8 helpers for the 1-Wire ROM search engine.
// ----------------------------------------------------------------------------
package owrs_pkg;

  localparam int ROM_BITS    = 64;
  localparam int CODE_BITS   = 56;
  localparam int FAMILY_BITS = 8;
  localparam int POS_W       = 7;
  localparam int FDISC_W     = 4;
  localparam logic [7:0] CRC_POLY = 8'h8C;

  localparam logic [2:0] FUNC_CLEAR   = 3'd0;
  localparam logic [2:0] FUNC_BEGIN   = 3'd1;
  localparam logic [2:0] FUNC_BITPAIR = 3'd2;
  localparam logic [2:0] FUNC_FAMILY  = 3'd3;
  localparam logic [2:0] FUNC_ROM     = 3'd4;
  localparam logic [2:0] FUNC_SKIP    = 3'd5;

  localparam logic [2:0] ST_ACCEPTED     = 3'd0;
  localparam logic [2:0] ST_NO_PRESENCE  = 3'd1;
  localparam logic [2:0] ST_PREV_LAST    = 3'd2;
  localparam logic [2:0] ST_BIT_CHOSEN   = 3'd3;
  localparam logic [2:0] ST_NO_RESPONSE  = 3'd4;
  localparam logic [2:0] ST_ROM_COMPLETE = 3'd5;
  localparam logic [2:0] ST_NOT_SEARCH   = 3'd6;

  typedef struct packed {
    logic [2:0]           func;
    logic                 presence;
    logic                 id_bit;
    logic                 complement_bit;
    logic [7:0]           family_code;
    logic [CODE_BITS-1:0] rom_value;
  } owrs_req_t;

  typedef struct packed {
    logic [2:0]           status;
    logic                 direction;
    logic [CODE_BITS-1:0] rom_code;
    logic [7:0]           crc_byte;
    logic                 crc_ok;
    logic                 last_device;
  } owrs_rsp_t;

  typedef logic [CODE_BITS-1:0][7:0] crc_cols_t;

  // CRC of a code with a single bit set; the CRC is linear with zero init
  function automatic crc_cols_t crc_cols();
    crc_cols_t  cols;
    logic [7:0] crc;
    logic       mix;
    for (int i = 0; i < CODE_BITS; i++) begin
      crc = CRC_POLY;
      for (int j = i + 1; j < CODE_BITS; j++) begin
        mix = crc[0];
        crc = crc >> 1;
        if (mix) begin
          crc = crc ^ CRC_POLY;
        end
      end
      cols[i] = crc;
    end
    return cols;
  endfunction

  localparam crc_cols_t CRC_COLS = crc_cols();

  function automatic logic [7:0] crc8(input logic [CODE_BITS-1:0] code);
    logic [7:0] crc;
    crc = '0;
    for (int i = 0; i < CODE_BITS; i++) begin
      if (code[i]) begin
        crc = crc ^ CRC_COLS[i];
      end
    end
    return crc;
  endfunction

endpackage
`default_nettype wire

// File: rtl/owrs_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owrs_if
// Valid/ready channels carrying operation items and result items.
// ----------------------------------------------------------------------------
interface owrs_req_if import owrs_pkg::*; ();
  logic      valid;
  logic      ready;
  owrs_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface owrs_rsp_if import owrs_pkg::*; ();
  logic      valid;
  logic      ready;
  owrs_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/onewire_rom_search_engine_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// onewire_rom_search_engine_top
// 1-Wire ROM search engine: one operation item in, one result item out.
//
//   channel  dir  payload
//   req      in   func, presence, id_bit, complement_bit, family_code,
//                 rom_value
//   rsp      out  status, direction, rom_code, crc_byte, crc_ok, last_device
//
// An item is registered on entry and resolved into the result register when
// that register is empty or being taken, updating the search state at the same edge.
// One item per cycle is sustained while rsp is taken.
// A stalled result holds the input register; req.ready drops only when both
// registers are full and rsp is not taken.
// rst clears the search state and both valid flags.
// ----------------------------------------------------------------------------
module onewire_rom_search_engine_top import owrs_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  owrs_req_if.sink   req,
  owrs_rsp_if.source rsp
);

  logic                 in_valid;
  owrs_req_t            in_item;
  logic                 out_valid;
  owrs_rsp_t            out_item;

  logic [ROM_BITS-1:0]  rom_bits, rom_bits_next;
  logic [POS_W-1:0]     bit_position, bit_position_next;
  logic [POS_W-1:0]     last_discrepancy, last_discrepancy_next;
  logic [FDISC_W-1:0]   family_discrepancy, family_discrepancy_next;
  logic [POS_W-1:0]     last_zero_position, last_zero_position_next;
  logic                 exhausted_flag, exhausted_flag_next;
  owrs_rsp_t            result;

  logic                 advance;
  logic                 dir;
  logic [5:0]           pos_m1;
  logic [CODE_BITS-1:0] code_now;

  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_item;
  assign pos_m1    = 6'(bit_position - POS_W'(1));
  assign code_now  = rom_bits_next[CODE_BITS-1:0];

  always_comb begin
    rom_bits_next           = rom_bits;
    bit_position_next       = bit_position;
    last_discrepancy_next   = last_discrepancy;
    family_discrepancy_next = family_discrepancy;
    last_zero_position_next = last_zero_position;
    exhausted_flag_next     = exhausted_flag;
    result                  = '0;
    dir                     = 1'b0;
    case (in_item.func)
      FUNC_CLEAR: begin
        exhausted_flag_next     = 1'b0;
        last_discrepancy_next   = '0;
        family_discrepancy_next = '0;
        bit_position_next       = '0;
      end
      FUNC_BEGIN: begin
        if (!in_item.presence || exhausted_flag) begin
          exhausted_flag_next     = 1'b0;
          last_discrepancy_next   = '0;
          family_discrepancy_next = '0;
          bit_position_next       = '0;
          result.status = !in_item.presence ? ST_NO_PRESENCE : ST_PREV_LAST;
        end else begin
          bit_position_next       = POS_W'(1);
          last_zero_position_next = '0;
        end
      end
      FUNC_BITPAIR: begin
        if (bit_position == '0 || bit_position > POS_W'(ROM_BITS)) begin
          bit_position_next = '0;
          result.status     = ST_NOT_SEARCH;
        end else if (in_item.id_bit && in_item.complement_bit) begin
          exhausted_flag_next     = 1'b0;
          last_discrepancy_next   = '0;
          family_discrepancy_next = '0;
          bit_position_next       = '0;
          result.status           = ST_NO_RESPONSE;
        end else begin
          if (!in_item.id_bit && !in_item.complement_bit) begin
            if (bit_position == last_discrepancy) begin
              dir = 1'b1;
            end else if (bit_position > last_discrepancy) begin
              dir = 1'b0;
            end else begin
              dir = rom_bits[pos_m1];
            end
            if (!dir) begin
              last_zero_position_next = bit_position;
              if (bit_position <= POS_W'(FAMILY_BITS)) begin
                family_discrepancy_next = bit_position[FDISC_W-1:0];
              end
            end
          end else begin
            dir = in_item.id_bit;
          end
          rom_bits_next[pos_m1] = dir;
          result.direction = dir;
          if (bit_position == POS_W'(ROM_BITS)) begin
            last_discrepancy_next = last_zero_position_next;
            if (last_zero_position_next == '0) begin
              exhausted_flag_next = 1'b1;
            end
            bit_position_next  = '0;
            result.status      = ST_ROM_COMPLETE;
            result.rom_code    = code_now;
            result.crc_byte    = rom_bits_next[ROM_BITS-1:CODE_BITS];
            result.crc_ok      = (crc8(code_now) == rom_bits_next[ROM_BITS-1:CODE_BITS]);
            result.last_device = exhausted_flag_next;
          end else begin
            bit_position_next = bit_position + POS_W'(1);
            result.status     = ST_BIT_CHOSEN;
          end
        end
      end
      FUNC_FAMILY: begin
        last_discrepancy_next   = POS_W'(ROM_BITS);
        family_discrepancy_next = '0;
        exhausted_flag_next     = 1'b0;
        bit_position_next       = '0;
        rom_bits_next = {rom_bits[ROM_BITS-1:CODE_BITS],
                         {(CODE_BITS-FAMILY_BITS){1'b0}}, in_item.family_code};
      end
      FUNC_ROM: begin
        last_discrepancy_next   = POS_W'(ROM_BITS);
        family_discrepancy_next = '0;
        exhausted_flag_next     = 1'b0;
        bit_position_next       = '0;
        rom_bits_next = {crc8(in_item.rom_value), in_item.rom_value};
      end
      FUNC_SKIP: begin
        last_discrepancy_next   = POS_W'(family_discrepancy);
        family_discrepancy_next = '0;
        exhausted_flag_next     = 1'b0;
        bit_position_next       = '0;
      end
      default: begin
        result.status = ST_NOT_SEARCH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid           <= 1'b0;
      out_valid          <= 1'b0;
      rom_bits           <= '0;
      bit_position       <= '0;
      last_discrepancy   <= '0;
      family_discrepancy <= '0;
      last_zero_position <= '0;
      exhausted_flag     <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid          <= 1'b1;
        rom_bits           <= rom_bits_next;
        bit_position       <= bit_position_next;
        last_discrepancy   <= last_discrepancy_next;
        family_discrepancy <= family_discrepancy_next;
        last_zero_position <= last_zero_position_next;
        exhausted_flag     <= exhausted_flag_next;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item <= req.data;
    end
    if (advance) begin
      out_item <= result;
    end
  end

endmodule
`default_nettype wire
